// File: hw/rtl/sha1bs_pkg.sv
// Shared types and constants for the SHA-1 byte stream hash.
// No dependencies; used by sha1bs_ctrl, sha1bs_dp and sha1_byte_stream_hash.
package sha1bs_pkg;

    // Request codes on the input channel
    localparam logic [1:0] REQ_DATA    = 2'd0;
    localparam logic [1:0] REQ_FINISH  = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // Status codes on the result channel
    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_DATA_AFTER = 2'd1;
    localparam logic [1:0] STS_OVERFLOW   = 2'd2;

    // Round group codes (selects f and K)
    localparam logic [1:0] GRP_CH     = 2'd0;
    localparam logic [1:0] GRP_PAR1   = 2'd1;
    localparam logic [1:0] GRP_MAJ    = 2'd2;
    localparam logic [1:0] GRP_PAR2   = 2'd3;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] GRP1_START = 7'd20;
    localparam logic [6:0] GRP2_START = 7'd40;
    localparam logic [6:0] GRP3_START = 7'd60;
    localparam logic [2:0] WORD_LAST  = 3'd4;
    localparam logic [7:0] PAD_MARK   = 8'h80;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Byte source for the block window shift
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } src_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FINAL,
        S_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       shift_en;
        src_t       shift_src;
        logic       len_inc;
        logic       len_clr;
        logic       fill_clr;
        logic       chain_init;
        logic       load_work;
        logic       round_en;
        logic [1:0] round_grp;
        logic       chain_add;
        logic       out_load;
        logic       out_is_word;
        logic [1:0] out_code;
        logic [2:0] out_idx;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic fill_last;
        logic fill_ge56;
        logic len_wrap;
    } dp_sts_t;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0:    h = 32'h67452301;
            3'd1:    h = 32'hEFCDAB89;
            3'd2:    h = 32'h98BADCFE;
            3'd3:    h = 32'h10325476;
            default: h = 32'hC3D2E1F0;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] round_k(input logic [1:0] grp);
        logic [31:0] k;
        case (grp)
            GRP_CH:   k = 32'h5A827999;
            GRP_PAR1: k = 32'h6ED9EBA1;
            GRP_MAJ:  k = 32'h8F1BBCDC;
            default:  k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

endpackage

// File: hw/rtl/sha1bs_dp.sv
// Datapath: block window / message schedule, working vars a..e, chaining
// words, length and fill counters, result register. Depends on sha1bs_pkg.
module sha1bs_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sha1bs_pkg::cmd_t       cmd,
    input  logic [7:0]             data_byte,
    output sha1bs_pkg::dp_sts_t    sts,
    output sha1bs_pkg::out_item_t  out_item
);

    logic [31:0] win_reg [16];
    logic [31:0] chain_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0] len_reg;
    logic [5:0]  fill_reg;
    sha1bs_pkg::out_item_t out_reg;

    logic [7:0]  shift_byte;
    logic [7:0]  len_byte;
    logic [31:0] f_val;
    logic [31:0] w_mix;
    logic [31:0] w_new;
    logic [31:0] t_val;

    assign sts.fill_last = (fill_reg == 6'd63);
    assign sts.fill_ge56 = (fill_reg[5:3] == 3'b111);
    assign sts.len_wrap  = &len_reg[63:3];
    assign out_item      = out_reg;

    // Length bytes go out big-endian, selected by the low fill bits
    assign len_byte = len_reg[{~fill_reg[2:0], 3'b000} +: 8];

    always_comb begin
        case (cmd.shift_src)
            sha1bs_pkg::SRC_DATA: shift_byte = data_byte;
            sha1bs_pkg::SRC_MARK: shift_byte = sha1bs_pkg::PAD_MARK;
            sha1bs_pkg::SRC_LEN:  shift_byte = len_byte;
            default:              shift_byte = 8'h00;
        endcase
    end

    // Round function
    always_comb begin
        case (cmd.round_grp)
            sha1bs_pkg::GRP_CH:  f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            sha1bs_pkg::GRP_MAJ: f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default:             f_val = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    assign w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};
    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + win_reg[0]
                 + sha1bs_pkg::round_k(cmd.round_grp);

    // Block window: byte shift while filling, word shift as schedule
    always_ff @(posedge aclk) begin
        if (cmd.shift_en) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_reg[15] <= {win_reg[15][23:0], shift_byte};
        end else if (cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_new;
        end
    end

    // Working variables
    always_ff @(posedge aclk) begin
        if (cmd.load_work) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end else if (cmd.round_en) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Chaining words
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.chain_init) begin
            for (int i = 0; i < 5; i++) begin
                chain_reg[i] <= sha1bs_pkg::init_hash(3'(i));
            end
        end else if (cmd.chain_add) begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
    end

    // Bit length and fill index
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.len_clr) begin
            len_reg <= '0;
        end else if (cmd.len_inc) begin
            len_reg <= len_reg + 64'd8;
        end
        if (!aresetn || cmd.fill_clr) begin
            fill_reg <= '0;
        end else if (cmd.shift_en) begin
            fill_reg <= fill_reg + 6'd1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_is_word) begin
                out_reg.status      <= sha1bs_pkg::STS_OK;
                out_reg.digest_word <= chain_reg[cmd.out_idx];
                out_reg.word_index  <= cmd.out_idx;
                out_reg.last_word   <= (cmd.out_idx == sha1bs_pkg::WORD_LAST);
            end else begin
                out_reg.status      <= cmd.out_code;
                out_reg.digest_word <= '0;
                out_reg.word_index  <= '0;
                out_reg.last_word   <= 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/sha1bs_ctrl.sv
// Controller: request decode, padding sequencer, round counter, digest emit.
// Drives sha1bs_dp through cmd_t. Depends on sha1bs_pkg.
module sha1bs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           req_type,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  sha1bs_pkg::dp_sts_t  sts,
    output sha1bs_pkg::cmd_t     cmd
);

    sha1bs_pkg::state_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic       finished_reg, finished_next;
    logic [1:0] err_reg, err_next;
    logic       mark_reg, mark_next;     // 0x80 already written
    logic       len_ok_reg, len_ok_next; // length bytes may go at 56..63
    logic       pad_reg, pad_next;       // padding in progress
    logic       last_reg, last_next;     // current block is the final one
    logic       m_valid_reg, m_valid_next;

    logic       out_free;
    logic       accept;
    logic [1:0] grp;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == sha1bs_pkg::S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        if (cnt_reg < sha1bs_pkg::GRP1_START) begin
            grp = sha1bs_pkg::GRP_CH;
        end else if (cnt_reg < sha1bs_pkg::GRP2_START) begin
            grp = sha1bs_pkg::GRP_PAR1;
        end else if (cnt_reg < sha1bs_pkg::GRP3_START) begin
            grp = sha1bs_pkg::GRP_MAJ;
        end else begin
            grp = sha1bs_pkg::GRP_PAR2;
        end
    end

    // Next state
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        finished_next = finished_reg;
        err_next      = err_reg;
        mark_next     = mark_reg;
        len_ok_next   = len_ok_reg;
        pad_next      = pad_reg;
        last_next     = last_reg;
        unique case (state_reg)
            sha1bs_pkg::S_IDLE: begin
                if (accept) begin
                    case (req_type)
                        sha1bs_pkg::REQ_DATA: begin
                            if (finished_reg) begin
                                err_next = sha1bs_pkg::STS_DATA_AFTER;
                            end else if (err_reg != sha1bs_pkg::STS_OK) begin
                                err_next = err_reg;
                            end else if (sts.len_wrap) begin
                                err_next = sha1bs_pkg::STS_OVERFLOW;
                            end else if (sts.fill_last) begin
                                state_next = sha1bs_pkg::S_ROUND;
                                cnt_next   = '0;
                            end
                        end
                        sha1bs_pkg::REQ_FINISH: begin
                            if (err_reg != sha1bs_pkg::STS_OK) begin
                                err_next = err_reg;
                            end else if (finished_reg) begin
                                state_next = sha1bs_pkg::S_EMIT;
                                cnt_next   = '0;
                            end else begin
                                state_next  = sha1bs_pkg::S_PAD;
                                mark_next   = 1'b0;
                                len_ok_next = 1'b0;
                                pad_next    = 1'b1;
                                last_next   = 1'b0;
                            end
                        end
                        sha1bs_pkg::REQ_RESTART: begin
                            finished_next = 1'b0;
                            err_next      = sha1bs_pkg::STS_OK;
                        end
                        default: ;
                    endcase
                end
            end
            sha1bs_pkg::S_PAD: begin
                mark_next = 1'b1;
                if (!mark_reg && !sts.fill_ge56) begin
                    len_ok_next = 1'b1;
                end
                if (sts.fill_last) begin
                    state_next  = sha1bs_pkg::S_ROUND;
                    cnt_next    = '0;
                    len_ok_next = 1'b1;
                    last_next   = mark_reg && len_ok_reg && sts.fill_ge56;
                end
            end
            sha1bs_pkg::S_ROUND: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == sha1bs_pkg::ROUND_LAST) begin
                    state_next = sha1bs_pkg::S_FINAL;
                end
            end
            sha1bs_pkg::S_FINAL: begin
                if (last_reg) begin
                    state_next    = sha1bs_pkg::S_EMIT;
                    cnt_next      = '0;
                    finished_next = 1'b1;
                    pad_next      = 1'b0;
                    last_next     = 1'b0;
                end else if (pad_reg) begin
                    state_next = sha1bs_pkg::S_PAD;
                end else begin
                    state_next = sha1bs_pkg::S_IDLE;
                end
            end
            sha1bs_pkg::S_EMIT: begin
                if (out_free) begin
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg[2:0] == sha1bs_pkg::WORD_LAST) begin
                        state_next = sha1bs_pkg::S_IDLE;
                    end
                end
            end
            default: state_next = sha1bs_pkg::S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd = '0;
        cmd.shift_src = sha1bs_pkg::SRC_ZERO;
        cmd.round_grp = grp;
        cmd.out_idx   = cnt_reg[2:0];
        unique case (state_reg)
            sha1bs_pkg::S_IDLE: begin
                if (accept) begin
                    case (req_type)
                        sha1bs_pkg::REQ_DATA: begin
                            if (finished_reg) begin
                                cmd.out_load = 1'b1;
                                cmd.out_code = sha1bs_pkg::STS_DATA_AFTER;
                            end else if (err_reg != sha1bs_pkg::STS_OK) begin
                                cmd.out_load = 1'b1;
                                cmd.out_code = err_reg;
                            end else begin
                                cmd.len_inc = 1'b1;
                                if (sts.len_wrap) begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_code = sha1bs_pkg::STS_OVERFLOW;
                                end else begin
                                    cmd.shift_en  = 1'b1;
                                    cmd.shift_src = sha1bs_pkg::SRC_DATA;
                                    cmd.load_work = sts.fill_last;
                                end
                            end
                        end
                        sha1bs_pkg::REQ_FINISH: begin
                            if (err_reg != sha1bs_pkg::STS_OK) begin
                                cmd.out_load = 1'b1;
                                cmd.out_code = err_reg;
                            end
                        end
                        sha1bs_pkg::REQ_RESTART: begin
                            cmd.chain_init = 1'b1;
                            cmd.len_clr    = 1'b1;
                            cmd.fill_clr   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            sha1bs_pkg::S_PAD: begin
                cmd.shift_en = 1'b1;
                if (!mark_reg) begin
                    cmd.shift_src = sha1bs_pkg::SRC_MARK;
                end else if (len_ok_reg && sts.fill_ge56) begin
                    cmd.shift_src = sha1bs_pkg::SRC_LEN;
                end else begin
                    cmd.shift_src = sha1bs_pkg::SRC_ZERO;
                end
                cmd.load_work = sts.fill_last;
            end
            sha1bs_pkg::S_ROUND: begin
                cmd.round_en = 1'b1;
            end
            sha1bs_pkg::S_FINAL: begin
                cmd.chain_add = 1'b1;
                cmd.len_clr   = last_reg;
            end
            sha1bs_pkg::S_EMIT: begin
                if (out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_is_word = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result valid: set on load, cleared when taken
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sha1bs_pkg::S_IDLE;
            cnt_reg      <= '0;
            finished_reg <= 1'b0;
            err_reg      <= sha1bs_pkg::STS_OK;
            mark_reg     <= 1'b0;
            len_ok_reg   <= 1'b0;
            pad_reg      <= 1'b0;
            last_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            finished_reg <= finished_next;
            err_reg      <= err_next;
            mark_reg     <= mark_next;
            len_ok_reg   <= len_ok_next;
            pad_reg      <= pad_next;
            last_reg     <= last_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule

// File: hw/rtl/sha1_byte_stream_hash.sv
// SHA-1 over a byte stream, one request per byte; top level.
// Instantiates sha1bs_ctrl and sha1bs_dp; depends on sha1bs_pkg.
//
// A data byte request shifts one byte into the block window; every 64th byte
// also starts the compression, 80 rounds at one per cycle, then folds the
// result into the chaining words. A finish request on an open message pads
// one byte per cycle up to the end of the block (and through a second block
// when fewer than 9 bytes remain), compresses, then returns five digest
// words, one per cycle when the result side is ready. Requests are taken one
// at a time and only while the result register is empty or being drained.
// Error and overflow conditions are sticky and answered with one status
// result; restart clears the chaining words, length, fill and sticky state.
module sha1_byte_stream_hash (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sha1bs_pkg::in_item_t  s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha1bs_pkg::out_item_t m_payload
);

    sha1bs_pkg::cmd_t    cmd;
    sha1bs_pkg::dp_sts_t sts;

    sha1bs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .req_type (s_payload.req_type),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sha1bs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .data_byte (s_payload.data_byte),
        .sts       (sts),
        .out_item  (m_payload)
    );

    // Requests are only taken when the result slot is free or draining
    a_ready_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("request taken while result slot is blocked");

    // Digest runs end on word 4
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == sha1bs_pkg::STS_OK)
            |-> (m_payload.last_word == (m_payload.word_index == sha1bs_pkg::WORD_LAST)))
        else $error("digest last_word does not match word index");

    // Status results carry no digest
    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status != sha1bs_pkg::STS_OK)
            |-> (m_payload.digest_word == 32'd0 && m_payload.word_index == 3'd0
                 && m_payload.last_word))
        else $error("status result carries digest fields");

    // A digest word is followed by the next one in order
    a_word_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_payload.status == sha1bs_pkg::STS_OK
            && !m_payload.last_word)
            |=> (m_valid && m_payload.word_index == $past(m_payload.word_index) + 3'd1))
        else $error("digest words out of order");

endmodule

// File: test/sha1_byte_stream_hash_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sha1_byte_stream_hash: byte requests in, digest words out.
// Holds its own SHA-1 predictor of the block; depends only on sha1bs_pkg and the RTL.
module sha1_byte_stream_hash_tb;

    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         DRAIN_CYCLES   = 400;
    localparam int         RESULT_HOLD    = 300;

    localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                        32'h10325476, 32'hC3D2E1F0};
    localparam logic [127:0] SHA1_K  = {32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC,
                                        32'hCA62C1D6};

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    sha1bs_pkg::in_item_t  s_payload = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    sha1bs_pkg::out_item_t m_payload;

    sha1_byte_stream_hash i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // Predicted hash state
    logic [31:0]           chain_q [5];
    logic [7:0]            block_q [64];
    int unsigned           fill_q;
    logic [63:0]           bit_count_q;
    logic                  sealed_q;
    logic [1:0]            sticky_sts_q;
    sha1bs_pkg::out_item_t awaited_words [$];

    int  fail_count   = 0;
    int  sent_count   = 0;
    int  checked      = 0;
    int  digest_runs  = 0;
    int  status_runs  = 0;
    int  idle_cycles  = 0;
    bit  full_rate    = 1'b0;
    bit  hold_req     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void sha1_clear();
        for (int i = 0; i < 5; i++) chain_q[i] = SHA1_IV[159 - 32 * i -: 32];
        for (int i = 0; i < 64; i++) block_q[i] = 8'h00;
        fill_q       = 0;
        bit_count_q  = '0;
        sealed_q     = 1'b0;
        sticky_sts_q = sha1bs_pkg::STS_OK;
    endfunction

    // 80-round compression of block_q into chain_q
    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = {block_q[4 * r], block_q[4 * r + 1], block_q[4 * r + 2], block_q[4 * r + 3]};
        for (r = 16; r < 80; r++) begin
            t    = w[r - 3] ^ w[r - 8] ^ w[r - 14] ^ w[r - 16];
            w[r] = {t[30:0], t[31]};
        end
        a = chain_q[0];
        b = chain_q[1];
        c = chain_q[2];
        d = chain_q[3];
        e = chain_q[4];
        for (r = 0; r < 80; r++) begin
            if (r < 20) f = (b & c) | (~b & d);
            else if (r < 40 || r >= 60) f = b ^ c ^ d;
            else f = (b & c) | (b & d) | (c & d);
            k = SHA1_K[127 - 32 * (r / 20) -: 32];
            t = {a[26:0], a[31:27]} + f + e + w[r] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_q[0] += a;
        chain_q[1] += b;
        chain_q[2] += c;
        chain_q[3] += d;
        chain_q[4] += e;
        fill_q = 0;
    endfunction

    // Mark byte, zero fill, big-endian length; a second block when under 9 bytes remain
    function automatic void sha1_pad_finish();
        int unsigned i;
        int unsigned j;
        i = fill_q & 63;
        block_q[i] = sha1bs_pkg::PAD_MARK;
        i++;
        if (i > 56) begin
            for (j = i; j < 64; j++) block_q[j] = 8'h00;
            sha1_compress();
            for (j = 0; j < 56; j++) block_q[j] = 8'h00;
        end else begin
            for (j = i; j < 56; j++) block_q[j] = 8'h00;
        end
        for (j = 0; j < 8; j++) block_q[56 + j] = bit_count_q[63 - 8 * j -: 8];
        sha1_compress();
        for (j = 0; j < 64; j++) block_q[j] = 8'h00;
        bit_count_q = '0;
        sealed_q    = 1'b1;
    endfunction

    function automatic void queue_status();
        awaited_words.push_back({sticky_sts_q, 32'h0, 3'd0, 1'b1});
        status_runs++;
    endfunction

    // Update the predicted state for one accepted request
    function automatic void sha1_absorb(input sha1bs_pkg::in_item_t req);
        case (req.req_type)
            sha1bs_pkg::REQ_DATA: begin
                if (sealed_q) begin
                    sticky_sts_q = sha1bs_pkg::STS_DATA_AFTER;
                    queue_status();
                end else if (sticky_sts_q != sha1bs_pkg::STS_OK) begin
                    queue_status();
                end else begin
                    bit_count_q = bit_count_q + 64'd8;
                    if (bit_count_q == '0) begin
                        sticky_sts_q = sha1bs_pkg::STS_OVERFLOW;
                        queue_status();
                    end else begin
                        block_q[fill_q & 63] = req.data_byte;
                        fill_q = (fill_q + 1) & 127;
                        if (fill_q >= 64) sha1_compress();
                    end
                end
            end
            sha1bs_pkg::REQ_FINISH: begin
                if (sticky_sts_q != sha1bs_pkg::STS_OK) begin
                    queue_status();
                end else begin
                    if (!sealed_q) sha1_pad_finish();
                    for (int i = 0; i < 5; i++)
                        awaited_words.push_back({sha1bs_pkg::STS_OK, chain_q[i], 3'(i),
                                                 i == 4});
                    digest_runs++;
                end
            end
            sha1bs_pkg::REQ_RESTART: sha1_clear();
            default: ;
        endcase
    endfunction

    function automatic void check_result(input sha1bs_pkg::out_item_t got);
        sha1bs_pkg::out_item_t want;
        checked++;
        if (awaited_words.size() == 0) begin
            $display("%0t: unexpected result sts=%0d word=%h idx=%0d last=%0d", $time,
                     got.status, got.digest_word, got.word_index, got.last_word);
            fail_count++;
        end else begin
            want = awaited_words.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                fail_count++;
            end
            if (got.digest_word !== want.digest_word) begin
                $display("%0t: digest_word expected %h actual %h", $time,
                         want.digest_word, got.digest_word);
                fail_count++;
            end
            if (got.word_index !== want.word_index) begin
                $display("%0t: word_index expected %0d actual %0d", $time,
                         want.word_index, got.word_index);
                fail_count++;
            end
            if (got.last_word !== want.last_word) begin
                $display("%0t: last_word expected %0d actual %0d", $time,
                         want.last_word, got.last_word);
                fail_count++;
            end
        end
    endfunction

    // Both channels observed at each edge: results first, then the new request
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_result(m_payload);
            if (s_valid && s_ready) sha1_absorb(s_payload);
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("%0t: watchdog expired, %0d results outstanding", $time, awaited_words.size());
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, full-rate stretches and one long hold on request
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = RESULT_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (full_rate) begin
                m_ready <= 1'b1;
            end else begin
                if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // One request; returns at the edge where it is accepted
    task automatic send_request(input logic [1:0] code, input logic [7:0] value);
        int gap;
        gap = full_rate ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= {code, value};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (code != REQ_UNUSED) sent_count++;
    endtask

    // Random message bytes with an occasional unused code mixed in
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 24) == 0)
                send_request(REQ_UNUSED, 8'($urandom_range(0, 255)));
            send_request(sha1bs_pkg::REQ_DATA, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_directed_cases();
        // empty message, then the stored digest again
        send_request(sha1bs_pkg::REQ_FINISH, 8'h00);
        send_request(sha1bs_pkg::REQ_FINISH, 8'hFF);
        // data after finish, then the sticky error on data and finish
        send_request(sha1bs_pkg::REQ_DATA, 8'hFF);
        send_request(sha1bs_pkg::REQ_DATA, 8'h00);
        send_request(sha1bs_pkg::REQ_FINISH, 8'h00);
        send_request(REQ_UNUSED, 8'hFF);
        send_request(sha1bs_pkg::REQ_RESTART, 8'hFF);
        // "abc" with an ignored request in the middle
        send_request(sha1bs_pkg::REQ_DATA, 8'h61);
        send_request(REQ_UNUSED, 8'h00);
        send_request(sha1bs_pkg::REQ_DATA, 8'h62);
        send_request(sha1bs_pkg::REQ_DATA, 8'h63);
        send_request(sha1bs_pkg::REQ_FINISH, 8'h00);
        send_request(sha1bs_pkg::REQ_RESTART, 8'h00);
        // byte extremes
        send_request(sha1bs_pkg::REQ_DATA, 8'h00);
        send_request(sha1bs_pkg::REQ_DATA, 8'hFF);
        send_request(sha1bs_pkg::REQ_FINISH, 8'h00);
        send_request(sha1bs_pkg::REQ_RESTART, 8'h00);
    endtask

    // Lengths that put the mark and length field exactly into the same block,
    // spill into a second block, or land on a block boundary
    task automatic test_pad_boundaries();
        int lens [4];
        lens = '{55, 56, 63, 64};
        foreach (lens[i]) begin
            send_request(sha1bs_pkg::REQ_RESTART, 8'($urandom_range(0, 255)));
            send_message(lens[i]);
            send_request(sha1bs_pkg::REQ_FINISH, 8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver holds off while requests keep coming, so the block stalls its input
    task automatic test_result_backpressure();
        hold_req = 1'b1;
        send_request(sha1bs_pkg::REQ_RESTART, 8'h00);
        send_message(5);
        repeat (3) send_request(sha1bs_pkg::REQ_FINISH, 8'($urandom_range(0, 255)));
        send_request(sha1bs_pkg::REQ_DATA, 8'hA5);
        send_request(sha1bs_pkg::REQ_FINISH, 8'h5A);
        send_request(sha1bs_pkg::REQ_RESTART, 8'h00);
    endtask

    task automatic test_back_to_back();
        full_rate = 1'b1;
        send_message(70);
        send_request(sha1bs_pkg::REQ_FINISH, 8'h00);
        send_request(sha1bs_pkg::REQ_FINISH, 8'h00);
        send_request(sha1bs_pkg::REQ_RESTART, 8'h00);
        full_rate = 1'b0;
    endtask

    task automatic test_random_messages(input int target);
        int start;
        int len;
        int r;
        start = sent_count;
        while (sent_count - start < target) begin
            full_rate = ($urandom_range(0, 7) == 0);
            send_request(sha1bs_pkg::REQ_RESTART, 8'($urandom_range(0, 255)));
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(0, 20);
            else if (r < 92) len = $urandom_range(21, 70);
            else len = $urandom_range(71, 130);
            send_message(len);
            // broken sequence: the next restart drops the open message
            if ($urandom_range(0, 19) == 0) continue;
            send_request(sha1bs_pkg::REQ_FINISH, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) < 3)
                send_request(sha1bs_pkg::REQ_FINISH, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 15) begin
                send_request(sha1bs_pkg::REQ_DATA, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0)
                    send_request(sha1bs_pkg::REQ_DATA, 8'($urandom_range(0, 255)));
                else
                    send_request(sha1bs_pkg::REQ_FINISH, 8'($urandom_range(0, 255)));
            end
        end
        full_rate = 1'b0;
    endtask

    initial begin
        sha1_clear();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_pad_boundaries();
        test_result_backpressure();
        test_back_to_back();
        test_random_messages(100);
        s_valid <= 1'b0;

        while (awaited_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d requests sent, %0d results checked (%0d digest runs, %0d status).",
                 sent_count, checked, digest_runs, status_runs);
        $display("Covered padding edges, repeated finish, sticky errors and result backpressure.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
